/* src/lz4d_pkg.sv */
// Package: shared types and constants of the LZ4 block decompressor.
`default_nettype none
package lz4d_pkg;

  // Fixed widths
  localparam int CFG_BITS        = 25;
  localparam int HIST_ADDR_BITS  = 16;
  localparam int HIST_DEPTH      = 1 << HIST_ADDR_BITS;
  localparam int COUNT_BITS_DEF  = 25;
  localparam int OUT_DEPTH       = 3;

  // Input op codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Parse phases
  localparam logic [2:0] PH_TOKEN     = 3'd0;
  localparam logic [2:0] PH_LIT_EXT   = 3'd1;
  localparam logic [2:0] PH_LITERALS  = 3'd2;
  localparam logic [2:0] PH_OFF_LO    = 3'd3;
  localparam logic [2:0] PH_OFF_HI    = 3'd4;
  localparam logic [2:0] PH_MATCH_EXT = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd1;
  localparam logic [2:0] ST_OVERRUN    = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_SIZE       = 3'd4;
  localparam logic [2:0] ST_MISUSE     = 3'd5;

  // Token constants
  localparam logic [7:0] EXT_MORE    = 8'hFF;
  localparam logic [3:0] NIBBLE_EXT  = 4'd15;
  localparam logic [4:0] MIN_MATCH   = 5'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       block_done;
    logic [2:0] status;
  } out_word_t;

  // Parser to history stage
  typedef struct packed {
    logic                      emit;
    logic                      is_copy;
    logic [HIST_ADDR_BITS-1:0] wr_addr;
    out_word_t                 word;
  } stage_t;

endpackage
`default_nettype wire

/* src/lz4d_parser.sv */
// Token/length/offset parser and block control state.
`default_nettype none
module lz4d_parser
  import lz4d_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire in_word_t                  in_word,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_BITS-1:0]       cfg_wdata,
  output logic [HIST_ADDR_BITS-1:0]      rd_addr,
  output logic                           stg_valid_r,
  output stage_t                         stg_r
);

  localparam int LW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  logic [2:0]            phase_r, phase_nxt;
  logic [3:0]            mnib_r, mnib_nxt;
  logic [COUNT_BITS-1:0] lit_rem_r, lit_rem_nxt;
  logic [15:0]           offset_r, offset_nxt;
  logic [COUNT_BITS-1:0] match_rem_r, match_rem_nxt;
  logic [CFG_BITS-1:0]   prod_r, prod_nxt;
  logic [2:0]            err_r, err_nxt;
  logic [CFG_BITS-1:0]   exp_r;

  logic [CFG_BITS-1:0]   room;
  logic [COUNT_BITS:0]   sat_sum;
  logic [COUNT_BITS-1:0] sat_val;
  logic [COUNT_BITS-1:0] base_len;
  logic                  pend;
  logic                  done;
  stage_t                stg_nxt;

  // Copy source sits offset bytes behind the write position
  assign rd_addr = prod_r[HIST_ADDR_BITS-1:0] - offset_r;

  assign room = (exp_r > prod_r) ? (exp_r - prod_r) : '0;
  assign pend = (phase_r == PH_TOKEN) && (match_rem_r != '0);

  // Saturating add of an extension byte onto the length being built
  always_comb begin
    base_len = (phase_r == PH_LIT_EXT) ? lit_rem_r : match_rem_r;
    sat_sum  = {1'b0, base_len} + (COUNT_BITS+1)'(in_word.data_byte);
    sat_val  = sat_sum[COUNT_BITS] ? '1 : sat_sum[COUNT_BITS-1:0];
  end

  // Per-item decode
  always_comb begin
    phase_nxt     = phase_r;
    mnib_nxt      = mnib_r;
    lit_rem_nxt   = lit_rem_r;
    offset_nxt    = offset_r;
    match_rem_nxt = match_rem_r;
    prod_nxt      = prod_r;
    err_nxt       = err_r;
    done          = 1'b0;
    stg_nxt       = '0;
    stg_nxt.wr_addr = prod_r[HIST_ADDR_BITS-1:0];

    if (in_word.op == OP_DRAIN) begin
      if (err_r == ST_OK) begin
        if (pend) begin
          stg_nxt.emit    = 1'b1;
          stg_nxt.is_copy = 1'b1;
          prod_nxt        = prod_r + CFG_BITS'(1);
          match_rem_nxt   = match_rem_r - COUNT_BITS'(1);
        end else begin
          err_nxt = ST_MISUSE;
        end
      end
    end else begin
      if (err_r == ST_OK && pend) begin
        err_nxt       = ST_MISUSE;
        match_rem_nxt = '0;
      end
      if (err_nxt == ST_OK) begin
        unique case (phase_r)
          PH_TOKEN: begin
            mnib_nxt    = in_word.data_byte[3:0];
            lit_rem_nxt = COUNT_BITS'(in_word.data_byte[7:4]);
            if (in_word.data_byte[7:4] == NIBBLE_EXT) begin
              phase_nxt = PH_LIT_EXT;
            end else begin
              if (LW'(in_word.data_byte[7:4]) > LW'(room)) err_nxt = ST_OVERRUN;
              phase_nxt = (in_word.data_byte[7:4] != 4'd0) ? PH_LITERALS : PH_OFF_LO;
            end
          end
          PH_LIT_EXT: begin
            lit_rem_nxt = sat_val;
            if (in_word.data_byte != EXT_MORE) begin
              if (LW'(sat_val) > LW'(room)) err_nxt = ST_OVERRUN;
              phase_nxt = (sat_val != '0) ? PH_LITERALS : PH_OFF_LO;
            end
          end
          PH_LITERALS: begin
            stg_nxt.emit = 1'b1;
            stg_nxt.word.out_byte = in_word.data_byte;
            prod_nxt    = prod_r + CFG_BITS'(1);
            lit_rem_nxt = lit_rem_r - COUNT_BITS'(1);
            if (lit_rem_r == COUNT_BITS'(1)) phase_nxt = PH_OFF_LO;
          end
          PH_OFF_LO: begin
            offset_nxt = {8'd0, in_word.data_byte};
            phase_nxt  = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            offset_nxt    = {in_word.data_byte, offset_r[7:0]};
            if (offset_nxt == 16'd0 || CFG_BITS'(offset_nxt) > prod_r)
              err_nxt = ST_BAD_OFFSET;
            match_rem_nxt = COUNT_BITS'(MIN_MATCH + {1'b0, mnib_r});
            if (mnib_r == NIBBLE_EXT) begin
              phase_nxt = PH_MATCH_EXT;
            end else begin
              if (LW'(MIN_MATCH + {1'b0, mnib_r}) > LW'(room) && err_nxt == ST_OK)
                err_nxt = ST_OVERRUN;
              phase_nxt = PH_TOKEN;
            end
          end
          PH_MATCH_EXT: begin
            match_rem_nxt = sat_val;
            if (in_word.data_byte != EXT_MORE) begin
              if (LW'(sat_val) > LW'(room)) err_nxt = ST_OVERRUN;
              phase_nxt = PH_TOKEN;
            end
          end
          default: begin
            phase_nxt = PH_TOKEN;
          end
        endcase
      end
      // Block end checks
      if (in_word.last_byte) begin
        done = 1'b1;
        if (err_nxt == ST_OK && phase_nxt != PH_OFF_LO) err_nxt = ST_TRUNCATED;
        if (err_nxt == ST_OK && prod_nxt != exp_r) err_nxt = ST_SIZE;
      end
    end

    stg_nxt.word.out_valid    = stg_nxt.emit;
    stg_nxt.word.block_done   = done;
    stg_nxt.word.status       = err_nxt;
    stg_nxt.word.copy_pending = !done && (err_nxt == ST_OK) &&
                                (phase_nxt == PH_TOKEN) && (match_rem_nxt != '0);

    // Block end clears everything but history and the size register
    if (done) begin
      phase_nxt     = PH_TOKEN;
      mnib_nxt      = '0;
      lit_rem_nxt   = '0;
      offset_nxt    = '0;
      match_rem_nxt = '0;
      prod_nxt      = '0;
      err_nxt       = ST_OK;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOKEN;
      mnib_r      <= '0;
      lit_rem_r   <= '0;
      offset_r    <= '0;
      match_rem_r <= '0;
      prod_r      <= '0;
      err_r       <= ST_OK;
      exp_r       <= '0;
      stg_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        mnib_r      <= mnib_nxt;
        lit_rem_r   <= lit_rem_nxt;
        offset_r    <= offset_nxt;
        match_rem_r <= match_rem_nxt;
        prod_r      <= prod_nxt;
        err_r       <= err_nxt;
      end
      if (cfg_we) exp_r <= cfg_wdata;
      stg_valid_r <= accept;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) stg_r <= stg_nxt;
  end

endmodule
`default_nettype wire

/* src/lz4d_history.sv */
// History window memory with forwarding of the write in flight.
`default_nettype none
module lz4d_history
  import lz4d_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [HIST_ADDR_BITS-1:0] rd_addr,
  input  wire logic                      wr_en,
  input  wire logic                      is_copy,
  input  wire logic [HIST_ADDR_BITS-1:0] wr_addr,
  input  wire logic [7:0]                lit_byte,
  output logic [7:0]                     byte_o
);

  logic [7:0]                mem [HIST_DEPTH];
  logic [7:0]                rdata_r;
  logic [HIST_ADDR_BITS-1:0] rd_addr_r;
  logic                      fwd_en_r;
  logic [HIST_ADDR_BITS-1:0] fwd_addr_r;
  logic [7:0]                fwd_data_r;

  // A write landing on the same edge as the memory read is not seen by it, so that byte is forwarded instead
  always_comb begin
    if (!is_copy) begin
      byte_o = lit_byte;
    end else if (fwd_en_r && fwd_addr_r == rd_addr_r) begin
      byte_o = fwd_data_r;
    end else begin
      byte_o = rdata_r;
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) mem[wr_addr] <= byte_o;
  end

  // Forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else begin
      fwd_en_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= byte_o;
    end
  end

endmodule
`default_nettype wire

/* src/lz4d_out_fifo.sv */
// Small result queue decoupling the pipeline from output stalls.
`default_nettype none
module lz4d_out_fifo
  import lz4d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_word_t push_word,
  input  wire logic      pop,
  output logic           not_empty,
  output out_word_t      head,
  output logic [1:0]     count_r
);

  out_word_t  ent [OUT_DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;

  assign not_empty = (count_r != 2'd0);
  assign head      = ent[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == 2'(OUT_DEPTH-1)) ? 2'd0 : wr_ptr_r + 2'd1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == 2'(OUT_DEPTH-1)) ? 2'd0 : rd_ptr_r + 2'd1;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr_r] <= push_word;
  end

endmodule
`default_nettype wire

/* src/lz4_block_decompressor.sv */
// Top level: LZ4 block decompressor, one compressed byte or drain word per cycle while in_stall is low.
// An accepted word passes the parser's stage register, then the output queue, on its way to out_data.
// Throughput: one word per cycle; in_stall rises only once out_stall has let the 3-entry
// queue plus the word in flight fill up. Copy reads forward the previous word's write.
// Reset (synchronous, rst_n low) clears parser, counters, error, size register and queue;
// history contents stay undefined until written and are not swept.
`default_nettype none
module lz4_block_decompressor
  import lz4d_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_word_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_word_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  logic                      accept;
  logic [HIST_ADDR_BITS-1:0] rd_addr;
  logic                      stg_valid_r;
  stage_t                    stg_r;
  logic [7:0]                hist_byte;
  out_word_t                 res_word;
  logic [1:0]                fifo_count;
  logic [2:0]                occupancy;

  // Stall when queue plus the word in flight would fill the queue
  assign occupancy = {1'b0, fifo_count} + 3'(stg_valid_r);
  assign in_stall  = (occupancy >= 3'(OUT_DEPTH));
  assign accept    = in_valid && !in_stall;

  lz4d_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_word    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rd_addr    (rd_addr),
    .stg_valid_r(stg_valid_r),
    .stg_r      (stg_r)
  );

  lz4d_history u_history (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (stg_valid_r && stg_r.emit),
    .is_copy (stg_r.is_copy),
    .wr_addr (stg_r.wr_addr),
    .lit_byte(stg_r.word.out_byte),
    .byte_o  (hist_byte)
  );

  // Fill in the resolved byte
  always_comb begin
    res_word = stg_r.word;
    if (stg_r.emit) res_word.out_byte = hist_byte;
  end

  lz4d_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (stg_valid_r),
    .push_word(res_word),
    .pop      (out_valid && !out_stall),
    .not_empty(out_valid),
    .head     (out_data),
    .count_r  (fifo_count)
  );

endmodule
`default_nettype wire
